// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file tdf_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define TDF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");

// property checked on every edge, reset included
`define TDF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed: %m");

`endif

// File: rtl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// types, constants and helpers of the timed duplicate filter
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int CALL_W   = 128;
    localparam int NUM_W    = 16;
    localparam int TIME_W   = 64;
    localparam int WIN_W    = 32;
    localparam int S_DATA_W = 208;
    localparam int M_DATA_W = 8;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd600000;

    // one remembered message, also used for the incoming key
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [NUM_W-1:0]  number;
        logic [63:0]       sender_hi;
        logic [63:0]       sender_lo;
    } t_entry;

    // verdict of the compare unit on one table entry
    typedef struct packed {
        logic free;
        logic expired;
        logic match;
        logic older;
    } t_eval;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    // callsign ends at its first zero byte, every later byte reads as zero
    function automatic logic [CALL_W-1:0] norm_call(input logic [CALL_W-1:0] call);
        logic              ended;
        logic [CALL_W-1:0] res;
        ended = 1'b0;
        res   = call;
        for (int b = 0; b < CALL_W / 8; b++) begin
            if (ended) begin
                res[b*8 +: 8] = 8'h00;
            end else if (call[b*8 +: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/tdf_table.sv
// ----------------------------------------------------------------------------
// tdf_table
// entry memory with registered read port and per-entry valid flops
// ----------------------------------------------------------------------------
module tdf_table
    import tdf_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output t_entry             o_rd_entry,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  t_entry             i_wr_entry,
    input  logic               i_clr_en,
    input  logic [IDX_W-1:0]   i_clr_addr,
    output logic [ENTRIES-1:0] o_valid
);

    t_entry             r_mem [ENTRIES];
    t_entry             r_rd_entry;
    logic [ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_valid    = r_valid;

endmodule

// File: rtl/tdf_unit.sv
// ----------------------------------------------------------------------------
// tdf_unit
// shared compare unit: age check, key match and oldest search on one entry
// ----------------------------------------------------------------------------
module tdf_unit
    import tdf_pkg::*;
(
    input  logic              i_valid,
    input  t_entry            i_entry,
    input  t_entry            i_key,
    input  logic [WIN_W-1:0]  i_window,
    input  logic              i_have_oldest,
    input  logic [TIME_W-1:0] i_oldest_time,
    output t_eval             o_eval
);

    logic [TIME_W-1:0] age;
    logic              expired;
    logic              live;

    // age wraps modulo 2^64, so an entry stamped in the future expires
    assign age     = i_key.time_ms - i_entry.time_ms;
    assign expired = i_valid && (age > {{(TIME_W-WIN_W){1'b0}}, i_window});
    assign live    = i_valid && !expired;

    always_comb begin
        o_eval.free    = !live;
        o_eval.expired = expired;
        o_eval.match   = live && (i_entry.number == i_key.number)
                         && (i_entry.sender_lo == i_key.sender_lo)
                         && (i_entry.sender_hi == i_key.sender_hi);
        o_eval.older   = live && (!i_have_oldest || (i_entry.time_ms < i_oldest_time));
    end

endmodule

// File: rtl/timed_duplicate_filter_top.sv
// ----------------------------------------------------------------------------
// timed_duplicate_filter_top
// time-window duplicate suppression over a small table of recent messages
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one message beat: sender callsign (two 64-bit words),
//   16-bit message number and the current time in milliseconds.
//   m_axis returns one beat per message, bit 0 set when the message is fresh
//   (recorded in the table) and clear when it is a duplicate.
//   i_cfg_we / i_cfg_wdata load the 32-bit age window in milliseconds.
// operation:
//   after a beat is taken the sequencer reads the table one entry per cycle
//   through a registered read port and feeds each entry to one compare unit.
//   the scan reads every entry, then a write state records a fresh message
//   and its result is loaded into the output register; a duplicate stops
//   the scan early at its matching entry.
//   s_axis_tready is high only while no message is in work, so the next
//   message is taken only once the last result is in the output register.
// reset:
//   synchronous, active low; all entries become invalid, window returns to
//   600000 ms, no output is pending.
// stall:
//   the result sits in an output register; while it waits the next message
//   can be accepted and scanned, then the sequencer holds until the register
//   frees up.
// ----------------------------------------------------------------------------
module timed_duplicate_filter_top
    import tdf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config: window_ms
    input  logic                i_cfg_we,
    input  logic [WIN_W-1:0]    i_cfg_wdata,
    // fields from bit 0: sender_lo[63:0], sender_hi[127:64],
    // message_number[143:128], time_now[207:144]
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // fields from bit 0: is_fresh[0], zero padding [7:1]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state              r_state;
    t_state              n_state;
    logic [WIN_W-1:0]    r_window;
    t_entry              r_key;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_rd_done;
    logic                r_ev_vld;
    logic [IDX_W-1:0]    r_ev_idx;
    logic                r_have_free;
    logic [IDX_W-1:0]    r_free_idx;
    logic                r_have_oldest;
    logic [IDX_W-1:0]    r_oldest_idx;
    logic [TIME_W-1:0]   r_oldest_time;
    logic                r_fresh;
    logic                r_out_valid;
    logic                r_out_fresh;

    logic                s_accept;
    logic                out_free;
    logic                rd_en;
    logic                wr_en;
    logic                clr_en;
    logic                load_out;
    logic                scan_hit;
    logic                scan_end;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              rd_entry;
    logic [TABLE_ENTRIES-1:0] valid_vec;
    t_eval               eval;
    logic [CALL_W-1:0]   in_call;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign in_call  = norm_call(s_axis_tdata[CALL_W-1:0]);

    // scan results, meaningful only while an entry is under evaluation
    assign scan_hit = r_ev_vld && eval.match;
    assign scan_end = r_ev_vld && (r_ev_idx == LAST_IDX) && !eval.match;

    // lowest free slot wins, else the oldest live entry is replaced
    assign wr_addr = r_have_free ? r_free_idx : r_oldest_idx;

    tdf_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_rd_idx),
        .o_rd_entry (rd_entry),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (r_key),
        .i_clr_en   (clr_en),
        .i_clr_addr (r_ev_idx),
        .o_valid    (valid_vec)
    );

    tdf_unit u_unit (
        .i_valid       (valid_vec[r_ev_idx]),
        .i_entry       (rd_entry),
        .i_key         (r_key),
        .i_window      (r_window),
        .i_have_oldest (r_have_oldest),
        .i_oldest_time (r_oldest_time),
        .o_eval        (eval)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_state = ST_DONE;
                end else if (scan_end) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        clr_en        = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN: begin
                rd_en  = !r_rd_done;
                // expired entries below a match are dropped too
                clr_en = r_ev_vld && eval.expired;
            end
            ST_WRITE: begin
                wr_en = 1'b1;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= WINDOW_RESET;
            r_rd_done   <= 1'b0;
            r_ev_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (s_accept) begin
                r_rd_done <= 1'b0;
                r_ev_vld  <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_ev_vld <= rd_en;
                if (rd_en && (r_rd_idx == LAST_IDX)) begin
                    r_rd_done <= 1'b1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key.sender_lo <= in_call[63:0];
            r_key.sender_hi <= in_call[127:64];
            r_key.number    <= s_axis_tdata[143:128];
            r_key.time_ms   <= s_axis_tdata[207:144];
            r_rd_idx        <= '0;
            r_have_free     <= 1'b0;
            r_have_oldest   <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            if (rd_en) begin
                r_ev_idx <= r_rd_idx;
                if (r_rd_idx != LAST_IDX) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (r_ev_vld) begin
                if (eval.free && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_ev_idx;
                end
                if (eval.older) begin
                    r_have_oldest <= 1'b1;
                    r_oldest_idx  <= r_ev_idx;
                    r_oldest_time <= rd_entry.time_ms;
                end
            end
        end
        if (scan_hit && (r_state == ST_SCAN)) begin
            r_fresh <= 1'b0;
        end else if (r_state == ST_WRITE) begin
            r_fresh <= 1'b1;
        end
        if (load_out) begin
            r_out_fresh <= r_fresh;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W-1){1'b0}}, r_out_fresh};

endmodule

// File: rtl/tdf_checker.sv
// ----------------------------------------------------------------------------
// tdf_checker
// port-level checks of the timed duplicate filter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdf_checker
    import tdf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    logic in_beat;
    logic out_stall;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a taken message keeps the input closed while it is scanned
    `TDF_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_beat |=> !s_axis_tready)

    // a stalled result beat stays put
    `TDF_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))

    // reset drops any pending result
    `TDF_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind timed_duplicate_filter_top tdf_checker u_tdf_checker (.*);

// File: tb/sv/tb_timed_duplicate_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_duplicate_filter_top
// self-checking bench for the time-window duplicate filter
// ----------------------------------------------------------------------------
// a clocked driver streams message beats from a backlog queue, a clocked
// monitor checks every result beat against a verdict worked out by a
// behavioral copy of the table at the moment the message beat is taken.
// a short directed run covers the corner cases, then random traffic built
// from a small pool of callsigns runs under several window settings and
// under three patterns of source and sink stalls
// ----------------------------------------------------------------------------
module tb_timed_duplicate_filter_top;
    import tdf_pkg::*;

    localparam int TABLE_N = 16;
    localparam int POOL_N  = 12;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [WIN_W-1:0]    i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // fields from bit 0: sender_lo[63:0], sender_hi[127:64],
    // message_number[143:128], time_now[207:144]
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // fields from bit 0: is_fresh[0], zero padding [7:1]
    logic [M_DATA_W-1:0] m_axis_tdata;

    timed_duplicate_filter_top #(
        .TABLE_ENTRIES(TABLE_N)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // behavioral copy of the message table
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]  window_ms_now = WINDOW_RESET;
    bit                seen_valid [TABLE_N];
    logic [CALL_W-1:0] seen_call  [TABLE_N];
    logic [NUM_W-1:0]  seen_number[TABLE_N];
    logic [TIME_W-1:0] seen_time  [TABLE_N];

    t_entry msg_backlog[$];     // message beats not yet driven
    bit     verdict_queue[$];   // expected is_fresh, oldest first
    int     results_owed  = 0;  // beats queued whose result has not come back
    int     fault_count   = 0;
    int     src_idle_pct  = 0;
    int     snk_idle_pct  = 0;

    // random traffic state
    logic [CALL_W-1:0] pool_call[POOL_N];
    int                pool_len [POOL_N];
    logic [NUM_W-1:0]  pool_num [POOL_N];
    logic [TIME_W-1:0] clock_ms;

    // zero every byte that follows the first zero byte
    function automatic logic [CALL_W-1:0] trim_call(input logic [CALL_W-1:0] call);
        int stop_at;
        stop_at = CALL_W / 8;
        for (int b = CALL_W / 8 - 1; b >= 0; b--) begin
            if (call[b*8 +: 8] == 8'h00) begin
                stop_at = b;
            end
        end
        for (int b = stop_at + 1; b < CALL_W / 8; b++) begin
            call[b*8 +: 8] = 8'h00;
        end
        return call;
    endfunction

    // scan the table from index 0, expire stale entries, stop on a live
    // match, otherwise record into the lowest free or the oldest live slot
    function automatic bit fresh_verdict(input t_entry msg);
        logic [CALL_W-1:0] call;
        logic [TIME_W-1:0] age;
        int                free_idx;
        int                oldest_idx;
        int                slot;
        call       = trim_call({msg.sender_hi, msg.sender_lo});
        free_idx   = -1;
        oldest_idx = -1;
        for (int i = 0; i < TABLE_N; i++) begin
            age = msg.time_ms - seen_time[i];
            if (!seen_valid[i]) begin
                if (free_idx < 0) free_idx = i;
            end else if (age > {32'd0, window_ms_now}) begin
                seen_valid[i] = 1'b0;
                if (free_idx < 0) free_idx = i;
            end else if (seen_number[i] == msg.number && seen_call[i] == call) begin
                return 1'b0;
            end else if (oldest_idx < 0 || seen_time[i] < seen_time[oldest_idx]) begin
                oldest_idx = i;
            end
        end
        slot = (free_idx >= 0) ? free_idx : oldest_idx;
        seen_valid[slot]  = 1'b1;
        seen_call[slot]   = call;
        seen_number[slot] = msg.number;
        seen_time[slot]   = msg.time_ms;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // source side: one beat per handshake, held while not taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            // the table is updated in acceptance order
            if (s_axis_tvalid && s_axis_tready) begin
                verdict_queue.push_back(fresh_verdict(t_entry'(s_axis_tdata)));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (msg_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= msg_backlog.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sink side: check each result beat, stall at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        bit want_fresh;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_queue.size() == 0) begin
                    $error("unexpected result beat, is_fresh %0b", m_axis_tdata[0]);
                    fault_count++;
                end else begin
                    want_fresh = verdict_queue.pop_front();
                    if (m_axis_tdata[0] !== want_fresh) begin
                        $error("is_fresh mismatch: expected %0b, actual %0b",
                               want_fresh, m_axis_tdata[0]);
                        fault_count++;
                    end
                    results_owed--;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_msg(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [NUM_W-1:0] num, input logic [TIME_W-1:0] t_ms);
        t_entry msg;
        msg.sender_lo = lo;
        msg.sender_hi = hi;
        msg.number    = num;
        msg.time_ms   = t_ms;
        results_owed++;
        msg_backlog.push_back(msg);
    endtask

    // nonzero characters up to len, zero after
    function automatic logic [CALL_W-1:0] build_call(input int len);
        logic [CALL_W-1:0] call;
        call = '0;
        for (int b = 0; b < len; b++) begin
            call[b*8 +: 8] = 8'($urandom_range(255, 1));
        end
        return call;
    endfunction

    // random junk after the terminating zero byte, which the block must ignore
    function automatic logic [CALL_W-1:0] add_junk(input logic [CALL_W-1:0] call,
                                                   input int len);
        for (int b = len + 1; b < CALL_W / 8; b++) begin
            call[b*8 +: 8] = 8'($urandom);
        end
        return call;
    endfunction

    // mostly pool traffic with a slowly moving clock, the rest pure noise
    task automatic queue_traffic(input int count, input int unsigned step_max);
        logic [CALL_W-1:0] call;
        logic [TIME_W-1:0] noise_t;
        int                k;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                k    = $urandom_range(POOL_N - 1);
                call = pool_call[k];
                if ($urandom_range(3) == 0) call = add_junk(call, pool_len[k]);
                if (pick < 25) begin
                    // same millisecond, gives ties for oldest
                end else if (pick < 28) begin
                    clock_ms = clock_ms - 64'($urandom_range(step_max * 3 + 2));
                end else begin
                    clock_ms = clock_ms + 64'($urandom_range(step_max));
                end
                push_msg(call[63:0], call[127:64],
                         pool_num[k] + NUM_W'($urandom_range(3)), clock_ms);
            end else begin
                noise_t = {$urandom, $urandom};
                push_msg({$urandom, $urandom}, {$urandom, $urandom},
                         NUM_W'($urandom), noise_t);
            end
        end
    endtask

    task automatic wait_drained();
        while (results_owed != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_window(input logic [WIN_W-1:0] w);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_ms_now = w;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [CALL_W-1:0] call_a;
        logic [CALL_W-1:0] call_b;
        for (int i = 0; i < TABLE_N; i++) begin
            seen_valid[i] = 1'b0;
        end
        for (int k = 0; k < POOL_N; k++) begin
            pool_len[k]  = ($urandom_range(4) == 0) ? $urandom_range(16) : $urandom_range(7, 3);
            pool_call[k] = build_call(pool_len[k]);
            pool_num[k]  = NUM_W'($urandom);
        end
        call_a = build_call(5);
        call_b = build_call(16);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, window still at its reset value
        src_idle_pct = 6;
        snk_idle_pct = 85;
        push_msg(call_a[63:0], call_a[127:64], 16'd1, 64'd100);
        push_msg(call_a[63:0], call_a[127:64], 16'd1, 64'd200);      // plain duplicate
        call_a = add_junk(call_a, 5);
        push_msg(call_a[63:0], call_a[127:64], 16'd1, 64'd300);      // junk after zero byte
        push_msg(call_a[63:0], call_a[127:64], 16'd2, 64'd600100);   // age equal to window
        push_msg(call_a[63:0], call_a[127:64], 16'd1, 64'd600101);   // age one past window
        push_msg(call_b[63:0], call_b[127:64], 16'd0, 64'd0);        // time goes backwards
        push_msg(64'd0, {$urandom, $urandom}, 16'd0, 64'd0);         // empty callsign
        // fill every slot at the same time stamp
        for (int i = 0; i < TABLE_N; i++) begin
            push_msg({8{8'hFF}} ^ 64'(i), '1, 16'hFFFF - NUM_W'(i), '1);
        end
        // full table, all tied for oldest
        push_msg(call_b[63:0], call_b[127:64], 16'd5, '1);
        push_msg({8{8'hFF}} ^ 64'd5, '1, 16'hFFFF - 16'd5, '1);      // live match mid table
        push_msg({8{8'hFF}}, '1, 16'hFFFF, '1);                      // evicted key comes back
        wait_drained();

        // short window, entries age out quickly
        load_window(32'd200);
        clock_ms = 64'd5000;
        queue_traffic(300, 60);
        wait_drained();

        // widest window, table stays full and the oldest gets replaced,
        // clock crosses the 64-bit wrap
        src_idle_pct = 85;
        snk_idle_pct = 6;
        load_window('1);
        clock_ms = 64'hFFFF_FFFF_FFFF_0000;
        queue_traffic(300, 20000);
        wait_drained();

        // zero window, only same-millisecond repeats are duplicates
        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_window(32'd0);
        clock_ms = {$urandom, $urandom};
        queue_traffic(150, 2);
        wait_drained();

        load_window(WINDOW_RESET);
        queue_traffic(150, 150000);
        wait_drained();

        if (fault_count == 0 && verdict_queue.size() == 0) begin
            $display("timed_duplicate_filter_top regression: pass");
        end else begin
            if (verdict_queue.size() != 0) begin
                $error("%0d expected results never arrived", verdict_queue.size());
            end
            $display("timed_duplicate_filter_top regression: fail");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5ms;
        $display("timed_duplicate_filter_top regression: fail");
        $finish;
    end

endmodule
